### src/mm_pkg.sv
// Package: shared constants, types and helpers for the matrix multiply block.
package mm_pkg;

  localparam int MAX_DIM     = 16;
  localparam int DATA_W      = 32;
  localparam int IDX_W       = 4;
  localparam int CFG_W       = 5;
  localparam int CFG_IDX_W   = 2;
  localparam int OP_W        = 2;
  localparam int DIM_W       = $clog2(MAX_DIM + 1);
  localparam int KIDX_W      = $clog2(MAX_DIM);
  localparam int STORE_DEPTH = MAX_DIM * MAX_DIM;
  localparam int ADDR_W      = $clog2(STORE_DEPTH);
  localparam int CMP_W       = (CFG_W > DIM_W) ? ((CFG_W > IDX_W) ? CFG_W : IDX_W)
                                               : ((DIM_W > IDX_W) ? DIM_W : IDX_W);
  localparam int CMDQ_DEPTH  = 2;

  localparam logic [OP_W-1:0] OP_LOAD_A = 2'd0;
  localparam logic [OP_W-1:0] OP_LOAD_B = 2'd1;
  localparam logic [OP_W-1:0] OP_QUERY  = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_ROWS_A    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_INNER_DIM = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_COLS_B    = 2'd2;

  typedef enum logic [1:0] {
    CMD_LOAD_A,
    CMD_LOAD_B,
    CMD_QUERY,
    CMD_QUERY_ERR
  } cmd_kind_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_DRAIN
  } back_state_e;

  typedef struct packed {
    cmd_kind_e         kind;
    logic [IDX_W-1:0]  row;
    logic [IDX_W-1:0]  col;
    logic [DIM_W-1:0]  n;
    logic [DATA_W-1:0] value;
  } cmd_t;

  function automatic logic [DIM_W-1:0] eff_dim(input logic [CFG_W-1:0] r);
    if (CMP_W'(r) > CMP_W'(MAX_DIM)) begin
      return DIM_W'(MAX_DIM);
    end
    return DIM_W'(r);
  endfunction

  function automatic logic idx_lt(input logic [IDX_W-1:0] idx, input logic [DIM_W-1:0] d);
    return CMP_W'(idx) < CMP_W'(d);
  endfunction

  function automatic logic [ADDR_W-1:0] store_addr(input logic [IDX_W-1:0] r,
                                                   input logic [IDX_W-1:0] c);
    logic [ADDR_W+IDX_W-1:0] full_addr;
    full_addr = (ADDR_W+IDX_W)'(r) * (ADDR_W+IDX_W)'(MAX_DIM) + (ADDR_W+IDX_W)'(c);
    return full_addr[ADDR_W-1:0];
  endfunction

endpackage

### src/mm_ram.sv
// Generic single-write, single-read RAM with registered read data.
module mm_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

### src/mm_front.sv
// Front end: configuration registers, item decode, range checks, command issue.
module mm_front (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_valid_i,
  input  logic [mm_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [mm_pkg::CFG_W-1:0]     cfg_data_i,
  input  logic                         push_i,
  input  logic                         full_i,
  input  logic [mm_pkg::OP_W-1:0]      op_i,
  input  logic [mm_pkg::IDX_W-1:0]     row_i,
  input  logic [mm_pkg::IDX_W-1:0]     col_i,
  input  logic [mm_pkg::DATA_W-1:0]    value_i,
  output logic                         cmd_push_o,
  output mm_pkg::cmd_t                 cmd_o
);
  import mm_pkg::*;

  logic [CFG_W-1:0] rows_a_q, inner_dim_q, cols_b_q;
  logic [DIM_W-1:0] m, n, q;
  logic             cmd_ok;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rows_a_q    <= CFG_W'(1);
      inner_dim_q <= CFG_W'(1);
      cols_b_q    <= CFG_W'(1);
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_ROWS_A:    rows_a_q    <= cfg_data_i;
        CFG_INNER_DIM: inner_dim_q <= cfg_data_i;
        CFG_COLS_B:    cols_b_q    <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign m = eff_dim(rows_a_q);
  assign n = eff_dim(inner_dim_q);
  assign q = eff_dim(cols_b_q);

  always_comb begin
    cmd_ok      = 1'b0;
    cmd_o.kind  = CMD_QUERY;
    cmd_o.row   = row_i;
    cmd_o.col   = col_i;
    cmd_o.n     = n;
    cmd_o.value = value_i;
    case (op_i)
      OP_LOAD_A: begin
        cmd_o.kind = CMD_LOAD_A;
        cmd_ok     = idx_lt(row_i, m) && idx_lt(col_i, n);
      end
      OP_LOAD_B: begin
        cmd_o.kind = CMD_LOAD_B;
        cmd_ok     = idx_lt(row_i, n) && idx_lt(col_i, q);
      end
      OP_QUERY: begin
        cmd_ok     = 1'b1;
        cmd_o.kind = (idx_lt(row_i, m) && idx_lt(col_i, q)) ? CMD_QUERY : CMD_QUERY_ERR;
      end
      default: cmd_ok = 1'b0;
    endcase
  end

  assign cmd_push_o = push_i && !full_i && cmd_ok;

endmodule

### src/mm_cmd_fifo.sv
// Short command queue between front end and back end.
module mm_cmd_fifo (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         push_i,
  input  mm_pkg::cmd_t cmd_i,
  output logic         full_o,
  input  logic         pop_i,
  output logic         valid_o,
  output mm_pkg::cmd_t cmd_o
);
  import mm_pkg::*;

  localparam int PTR_W = (CMDQ_DEPTH > 1) ? $clog2(CMDQ_DEPTH) : 1;
  localparam int CNT_W = $clog2(CMDQ_DEPTH + 1);

  cmd_t             mem_q [CMDQ_DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == CNT_W'(CMDQ_DEPTH));
  assign valid_o = (cnt_q != '0);
  assign cmd_o   = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(CMDQ_DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(CMDQ_DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + CNT_W'(1);
    end else if (!do_push && do_pop) begin
      cnt_d = cnt_q - CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= cmd_i;
    end
  end

endmodule

### src/mm_back.sv
// Back end: element stores, multiply-accumulate sequencer and result register.
module mm_back (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cmd_valid_i,
  input  mm_pkg::cmd_t              cmd_i,
  output logic                      cmd_pop_o,
  output logic                      empty_o,
  input  logic                      pop_i,
  output logic [mm_pkg::DATA_W-1:0] product_o,
  output logic                      status_o
);
  import mm_pkg::*;

  back_state_e       st_q, st_d;
  logic [DIM_W-1:0]  k_q, k_d;
  logic [IDX_W-1:0]  row_q, row_d, col_q, col_d;
  logic [DIM_W-1:0]  n_q, n_d;
  logic              rd_v_q, rd_v_d, rd_last_q, rd_last_d;
  logic              prod_v_q, prod_last_q;
  logic [DATA_W-1:0] prod_q, prod_d;
  logic [DATA_W-1:0] acc_q, acc_d;
  logic              out_v_q, out_v_d, out_status_q, out_status_d;
  logic [DATA_W-1:0] out_prod_q, out_prod_d;
  logic              we_a, we_b;
  logic [ADDR_W-1:0] waddr, raddr_a, raddr_b;
  logic [DATA_W-1:0] rdata_a, rdata_b;
  logic [IDX_W-1:0]  k_idx;

  assign k_idx   = IDX_W'(k_q[KIDX_W-1:0]);
  assign waddr   = store_addr(cmd_i.row, cmd_i.col);
  assign raddr_a = store_addr(row_q, k_idx);
  assign raddr_b = store_addr(k_idx, col_q);
  assign prod_d  = rdata_a * rdata_b;

  mm_ram #(.WIDTH(DATA_W), .DEPTH(STORE_DEPTH)) u_store_a (
    .clk_i  (clk_i),
    .we_i   (we_a),
    .waddr_i(waddr),
    .wdata_i(cmd_i.value),
    .raddr_i(raddr_a),
    .rdata_o(rdata_a)
  );

  mm_ram #(.WIDTH(DATA_W), .DEPTH(STORE_DEPTH)) u_store_b (
    .clk_i  (clk_i),
    .we_i   (we_b),
    .waddr_i(waddr),
    .wdata_i(cmd_i.value),
    .raddr_i(raddr_b),
    .rdata_o(rdata_b)
  );

  always_comb begin
    st_d         = st_q;
    k_d          = k_q;
    row_d        = row_q;
    col_d        = col_q;
    n_d          = n_q;
    rd_v_d       = 1'b0;
    rd_last_d    = 1'b0;
    acc_d        = prod_v_q ? acc_q + prod_q : acc_q;
    out_v_d      = out_v_q && !pop_i;
    out_prod_d   = out_prod_q;
    out_status_d = out_status_q;
    cmd_pop_o    = 1'b0;
    we_a         = 1'b0;
    we_b         = 1'b0;
    case (st_q)
      ST_IDLE: begin
        if (cmd_valid_i) begin
          case (cmd_i.kind)
            CMD_LOAD_A: begin
              we_a      = 1'b1;
              cmd_pop_o = 1'b1;
            end
            CMD_LOAD_B: begin
              we_b      = 1'b1;
              cmd_pop_o = 1'b1;
            end
            CMD_QUERY_ERR: begin
              if (!out_v_q) begin
                cmd_pop_o    = 1'b1;
                out_v_d      = 1'b1;
                out_prod_d   = '0;
                out_status_d = 1'b1;
              end
            end
            CMD_QUERY: begin
              if (!out_v_q) begin
                cmd_pop_o = 1'b1;
                if (cmd_i.n == '0) begin
                  out_v_d      = 1'b1;
                  out_prod_d   = '0;
                  out_status_d = 1'b0;
                end else begin
                  st_d  = ST_RUN;
                  k_d   = '0;
                  row_d = cmd_i.row;
                  col_d = cmd_i.col;
                  n_d   = cmd_i.n;
                  acc_d = '0;
                end
              end
            end
            default: ;
          endcase
        end
      end
      ST_RUN: begin
        rd_v_d    = 1'b1;
        rd_last_d = (k_q + DIM_W'(1) == n_q);
        k_d       = k_q + DIM_W'(1);
        if (rd_last_d) begin
          st_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (prod_v_q && prod_last_q) begin
          out_v_d      = 1'b1;
          out_prod_d   = acc_q + prod_q;
          out_status_d = 1'b0;
          st_d         = ST_IDLE;
        end
      end
      default: st_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= ST_IDLE;
      rd_v_q      <= 1'b0;
      rd_last_q   <= 1'b0;
      prod_v_q    <= 1'b0;
      prod_last_q <= 1'b0;
      out_v_q     <= 1'b0;
    end else begin
      st_q        <= st_d;
      rd_v_q      <= rd_v_d;
      rd_last_q   <= rd_last_d;
      prod_v_q    <= rd_v_q;
      prod_last_q <= rd_last_q;
      out_v_q     <= out_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    k_q          <= k_d;
    row_q        <= row_d;
    col_q        <= col_d;
    n_q          <= n_d;
    prod_q       <= prod_d;
    acc_q        <= acc_d;
    out_prod_q   <= out_prod_d;
    out_status_q <= out_status_d;
  end

  assign empty_o   = !out_v_q;
  assign product_o = out_prod_q;
  assign status_o  = out_status_q;

endmodule

### src/matrix_multiply.sv
// Integer matrix product C = A x B: element loads into A and B, element queries of C.
// Loads and queries enter through a two-item command queue; a query in range steps k
// below n (result 0 if n is 0), n being the inner dimension capped at 16, using one
// multiply-accumulate fed by one read port on each 256-entry element store. Loads outside
// the configured shape and op code 3 are dropped without a result. Store entries hold no
// value until written and need no clearing after reset. A finished result sits in an
// output register while the front keeps accepting items; the user must write configuration
// only while the block is idle, which the block itself does not enforce.
module matrix_multiply (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [mm_pkg::CFG_IDX_W-1:0]        cfg_index_i,
  input  logic [mm_pkg::CFG_W-1:0]            cfg_data_i,
  input  logic                                push,
  output logic                                full,
  input  logic [mm_pkg::OP_W-1:0]             op_i,
  input  logic [mm_pkg::IDX_W-1:0]            row_i,
  input  logic [mm_pkg::IDX_W-1:0]            col_i,
  input  logic signed [mm_pkg::DATA_W-1:0]    value_i,
  output logic                                empty,
  input  logic                                pop,
  output logic signed [mm_pkg::DATA_W-1:0]    product_o,
  output logic                                status_o
);
  import mm_pkg::*;

  cmd_t              front_cmd, head_cmd;
  logic              front_push, head_valid, head_pop;
  logic [DATA_W-1:0] product;

  assign cfg_ready_o = 1'b1;

  mm_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_valid_i(cfg_valid_i),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i (cfg_data_i),
    .push_i     (push),
    .full_i     (full),
    .op_i       (op_i),
    .row_i      (row_i),
    .col_i      (col_i),
    .value_i    (DATA_W'(unsigned'(value_i))),
    .cmd_push_o (front_push),
    .cmd_o      (front_cmd)
  );

  mm_cmd_fifo u_cmd_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (front_push),
    .cmd_i  (front_cmd),
    .full_o (full),
    .pop_i  (head_pop),
    .valid_o(head_valid),
    .cmd_o  (head_cmd)
  );

  mm_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_valid_i(head_valid),
    .cmd_i      (head_cmd),
    .cmd_pop_o  (head_pop),
    .empty_o    (empty),
    .pop_i      (pop),
    .product_o  (product),
    .status_o   (status_o)
  );

  assign product_o = signed'(product);

endmodule

### src/mm_chk.sv
// Port-level checker for the matrix multiply block, bound to the top level.
module mm_chk (
  input logic                             clk_i,
  input logic                             rst_ni,
  input logic                             empty,
  input logic                             pop,
  input logic signed [mm_pkg::DATA_W-1:0] product_o,
  input logic                             status_o
);
  import mm_pkg::*;

  a_empty_after_reset: assert property (@(posedge clk_i) !rst_ni |=> empty)
    else $error("result visible right after reset");

  a_result_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty && !pop |=> !empty && $stable(product_o) && $stable(status_o))
    else $error("waiting result changed or vanished");

  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty && status_o |-> product_o == '0)
    else $error("error result carries nonzero product");

endmodule

bind matrix_multiply mm_chk u_mm_chk (
  .clk_i    (clk_i),
  .rst_ni   (rst_ni),
  .empty    (empty),
  .pop      (pop),
  .product_o(product_o),
  .status_o (status_o)
);
